// ===== rtl/cts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS color token scanner package
// Scanner state codes, token kinds, character codes and the step result.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Scanner mode: idle, inside a hex run, partial prefixes, inside a function.
    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_HEX  = 4'd1,
        M_R    = 4'd2,
        M_RG   = 4'd3,
        M_RGB  = 4'd4,
        M_RGBA = 4'd5,
        M_H    = 4'd6,
        M_HS   = 4'd7,
        M_HSL  = 4'd8,
        M_HSLA = 4'd9,
        M_FUNC = 4'd10
    } mode_t;

    // Token kind codes as reported on the output.
    localparam logic [2:0] K_HEX  = 3'd0;
    localparam logic [2:0] K_RGB  = 3'd1;
    localparam logic [2:0] K_RGBA = 3'd2;
    localparam logic [2:0] K_HSL  = 3'd3;
    localparam logic [2:0] K_HSLA = 3'd4;

    // Characters the automaton reacts to.
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;

    // Hex run limits.
    localparam logic [2:0] HEX_MIN_DIGITS  = 3'd3;
    localparam logic [2:0] HEX_LAST_DIGITS = 3'd7;
    localparam logic [3:0] HEX_FULL_LEN    = 4'd9;

    // What one scanner step reports besides its next state.
    typedef struct packed {
        logic       emit;     // a token ends on this byte
        logic       is_func;  // token length comes from the offsets
        logic [2:0] kind;     // token kind code
        logic [3:0] hex_len;  // length of a hex token
        logic       mark;     // this byte opens a candidate token
    } step_res_t;

endpackage

// ===== rtl/css_color_token_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS color token scanner
// Reports hex colors and rgb/rgba/hsl/hsla functions as kind, offset, length.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-----------------------------------------
//  text    | text_valid / text_ready    | text_byte, end_of_text
//  token   | token_valid / token_ready  | token_kind, token_start, token_length,
//          |                            | token_index
//
// One text beat per cycle while the token register can take a result; a beat
// enters an input register, is scanned from there, and its token, if any, is
// written into the output register. The per-byte automaton step sets the rate.
// Reset clears the scanner to idle with offset and token count at zero.
// A stalled token register holds the scanner; the input register still takes
// one more beat, and text_ready drops only when both are full.
// ----------------------------------------------------------------------------
module css_color_token_scanner
    import cts_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32,
    parameter int DEPTH_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [2:0]  token_kind,
    output logic [31:0] token_start,
    output logic [31:0] token_length,
    output logic [31:0] token_index
);

    // Input register.
    logic                    s_valid_reg;
    logic [7:0]              s_byte_reg;
    logic                    s_last_reg;

    // Scanner state.
    mode_t                   mode_reg;
    logic [2:0]              digits_reg;
    logic [DEPTH_WIDTH-1:0]  depth_reg;
    logic [2:0]              fkind_reg;
    logic [OFFSET_WIDTH-1:0] origin_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [31:0]             count_reg;

    // Output register.
    logic                    o_valid_reg;
    logic [2:0]              o_kind_reg;
    logic [31:0]             o_start_reg;
    logic [31:0]             o_length_reg;
    logic [31:0]             o_index_reg;

    mode_t                   mode_next;
    logic [2:0]              digits_next;
    logic [DEPTH_WIDTH-1:0]  depth_next;
    logic [2:0]              fkind_next;
    step_res_t               res;

    logic                    proc;
    logic                    flush;
    logic                    emit;
    logic [2:0]              kind;
    logic [3:0]              hex_len;
    logic [OFFSET_WIDTH-1:0] length_full;
    logic [31:0]             length_32;
    logic [31:0]             start_32;

    // The scanner steps when a byte waits and the token register can take a result.
    assign proc       = s_valid_reg && (!o_valid_reg || token_ready);
    assign text_ready = !s_valid_reg || proc;

    cts_fsm #(
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_fsm (
        .text_byte   (s_byte_reg),
        .mode        (mode_reg),
        .digits      (digits_reg),
        .depth       (depth_reg),
        .fkind       (fkind_reg),
        .mode_next   (mode_next),
        .digits_next (digits_next),
        .depth_next  (depth_next),
        .fkind_next  (fkind_next),
        .res         (res)
    );

    // End of text flushes a pending hex run of three or more digits.
    assign flush   = s_last_reg && !res.emit && (mode_next == M_HEX)
                     && (digits_next >= HEX_MIN_DIGITS);
    assign emit    = res.emit || flush;
    assign kind    = flush ? K_HEX : res.kind;
    assign hex_len = flush ? ({1'b0, digits_next} + 4'd1) : res.hex_len;

    // Token length: offset span for functions, digit count plus the '#' for hex runs.
    assign length_full = res.is_func
                         ? (offset_reg - origin_reg + 1'b1)
                         : {{(OFFSET_WIDTH-4){1'b0}}, hex_len};

    // Offsets are reported in 32 bits.
    if (OFFSET_WIDTH >= 32)
    begin : g_wide
        assign length_32 = length_full[31:0];
        assign start_32  = origin_reg[31:0];
    end
    else
    begin : g_narrow
        assign length_32 = {{(32-OFFSET_WIDTH){1'b0}}, length_full};
        assign start_32  = {{(32-OFFSET_WIDTH){1'b0}}, origin_reg};
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            s_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
        begin
            s_byte_reg <= text_byte;
            s_last_reg <= end_of_text;
        end
    end

    // Scanner state; the last byte of a text returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            digits_reg <= '0;
            depth_reg  <= '0;
            fkind_reg  <= '0;
            origin_reg <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
        end
        else if (proc)
        begin
            if (s_last_reg)
            begin
                mode_reg   <= M_IDLE;
                digits_reg <= '0;
                depth_reg  <= '0;
                fkind_reg  <= '0;
                origin_reg <= '0;
                offset_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                mode_reg   <= mode_next;
                digits_reg <= digits_next;
                depth_reg  <= depth_next;
                fkind_reg  <= fkind_next;
                offset_reg <= offset_reg + 1'b1;
                if (res.mark)
                begin
                    origin_reg <= offset_reg;
                end
                if (emit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Token register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (proc)
        begin
            o_valid_reg <= emit;
        end
        else if (token_ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            o_kind_reg   <= kind;
            o_start_reg  <= start_32;
            o_length_reg <= length_32;
            o_index_reg  <= count_reg;
        end
    end

    assign token_valid  = o_valid_reg;
    assign token_kind   = o_kind_reg;
    assign token_start  = o_start_reg;
    assign token_length = o_length_reg;
    assign token_index  = o_index_reg;

    // Inside a function the nesting depth never drops to zero.
    a_func_depth: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_FUNC |-> depth_reg != '0)
        else $error("function mode with zero paren depth");

    // The hex digit count is only nonzero inside a hex run.
    a_digits_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != M_HEX |-> digits_reg == '0)
        else $error("hex digit count outside a hex run");

    // The last byte of a text leaves the scanner at reset.
    a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
        proc && s_last_reg |=> mode_reg == M_IDLE && offset_reg == '0
                               && count_reg == '0)
        else $error("scanner not reset after end of text");

    // Hex tokens are four to nine bytes long.
    a_hex_len: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == K_HEX |-> token_length >= 32'd4
                                               && token_length <= 32'd9)
        else $error("hex token length out of range");

    // A waiting token is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !token_ready |-> !proc)
        else $error("scanner stepped while token register was full");

endmodule

// ===== rtl/cts_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS color token scanner step logic
// Combinational next state of the prefix automaton, hex run and paren depth.
// ----------------------------------------------------------------------------
module cts_fsm
    import cts_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16
)
(
    input  logic [7:0]             text_byte,
    input  mode_t                  mode,
    input  logic [2:0]             digits,
    input  logic [DEPTH_WIDTH-1:0] depth,
    input  logic [2:0]             fkind,
    output mode_t                  mode_next,
    output logic [2:0]             digits_next,
    output logic [DEPTH_WIDTH-1:0] depth_next,
    output logic [2:0]             fkind_next,
    output step_res_t              res
);

    logic                   is_hex;
    logic                   rescan;
    logic [DEPTH_WIDTH-1:0] depth_dec;

    // Hex digit classes: 0-9, a-f, A-F.
    always_comb
    begin
        is_hex = text_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    end

    assign depth_dec = (depth != '0) ? depth - 1'b1 : depth;

    // One automaton step; a broken prefix falls back to idle and rescans the byte.
    always_comb
    begin
        mode_next   = mode;
        digits_next = digits;
        depth_next  = depth;
        fkind_next  = fkind;
        res         = '0;
        rescan      = 1'b0;

        case (mode)
            M_HEX:
            begin
                if (is_hex)
                begin
                    if (digits == HEX_LAST_DIGITS)
                    begin
                        res.emit    = 1'b1;
                        res.kind    = K_HEX;
                        res.hex_len = HEX_FULL_LEN;
                        mode_next   = M_IDLE;
                        digits_next = '0;
                    end
                    else
                    begin
                        digits_next = digits + 1'b1;
                    end
                end
                else
                begin
                    if (digits >= HEX_MIN_DIGITS)
                    begin
                        res.emit    = 1'b1;
                        res.kind    = K_HEX;
                        res.hex_len = {1'b0, digits} + 4'd1;
                    end
                    digits_next = '0;
                    rescan      = 1'b1;
                end
            end
            M_FUNC:
            begin
                if (text_byte == CH_LPAREN)
                begin
                    if (depth != '1)
                    begin
                        depth_next = depth + 1'b1;
                    end
                end
                else if (text_byte == CH_RPAREN)
                begin
                    depth_next = depth_dec;
                    if (depth_dec == '0)
                    begin
                        res.emit    = 1'b1;
                        res.is_func = 1'b1;
                        res.kind    = fkind;
                        mode_next   = M_IDLE;
                        fkind_next  = '0;
                    end
                end
            end
            M_R:
            begin
                if (text_byte == CH_G) mode_next = M_RG;
                else rescan = 1'b1;
            end
            M_RG:
            begin
                if (text_byte == CH_B) mode_next = M_RGB;
                else rescan = 1'b1;
            end
            M_RGB:
            begin
                if (text_byte == CH_A)
                begin
                    mode_next = M_RGBA;
                end
                else if (text_byte == CH_LPAREN)
                begin
                    mode_next  = M_FUNC;
                    fkind_next = K_RGB;
                    depth_next = DEPTH_WIDTH'(1);
                end
                else
                begin
                    rescan = 1'b1;
                end
            end
            M_RGBA:
            begin
                if (text_byte == CH_LPAREN)
                begin
                    mode_next  = M_FUNC;
                    fkind_next = K_RGBA;
                    depth_next = DEPTH_WIDTH'(1);
                end
                else
                begin
                    rescan = 1'b1;
                end
            end
            M_H:
            begin
                if (text_byte == CH_S) mode_next = M_HS;
                else rescan = 1'b1;
            end
            M_HS:
            begin
                if (text_byte == CH_L) mode_next = M_HSL;
                else rescan = 1'b1;
            end
            M_HSL:
            begin
                if (text_byte == CH_A)
                begin
                    mode_next = M_HSLA;
                end
                else if (text_byte == CH_LPAREN)
                begin
                    mode_next  = M_FUNC;
                    fkind_next = K_HSL;
                    depth_next = DEPTH_WIDTH'(1);
                end
                else
                begin
                    rescan = 1'b1;
                end
            end
            M_HSLA:
            begin
                if (text_byte == CH_LPAREN)
                begin
                    mode_next  = M_FUNC;
                    fkind_next = K_HSLA;
                    depth_next = DEPTH_WIDTH'(1);
                end
                else
                begin
                    rescan = 1'b1;
                end
            end
            default:
            begin
                rescan = 1'b1;
            end
        endcase

        // Scan the byte from idle.
        if (rescan)
        begin
            mode_next = M_IDLE;
            case (text_byte)
                CH_HASH:
                begin
                    mode_next   = M_HEX;
                    digits_next = '0;
                    res.mark    = 1'b1;
                end
                CH_R:
                begin
                    mode_next = M_R;
                    res.mark  = 1'b1;
                end
                CH_H:
                begin
                    mode_next = M_H;
                    res.mark  = 1'b1;
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSS color token scanner testbench
// Streams CSS text beats into the scanner, predicts every color token with a
// local model of the scanner and checks each token beat field by field.
// ----------------------------------------------------------------------------
module tb_top
    import cts_pkg::*;
();

    localparam int OFFSET_WIDTH = 32;
    localparam int DEPTH_WIDTH  = 16;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = '1;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 880;
    localparam int NEST_LEVELS  = 30;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // Hex digit ranges and the longest hex run.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [3:0] HEX_MAX_DIGITS = 4'd8;

    // Fragment shapes of the random text.
    typedef enum int {
        FRAG_HEX,
        FRAG_FUNC,
        FRAG_BROKEN,
        FRAG_NOISE
    } frag_kind_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] index;
    } color_token_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        text_valid  = 1'b0;
    logic [7:0]  text_byte   = CH_SPACE;
    logic        end_of_text = 1'b0;
    logic        token_ready = 1'b0;
    logic        text_ready;
    logic        token_valid;
    logic [2:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [31:0] token_index;

    css_color_token_scanner #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .DEPTH_WIDTH  (DEPTH_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_index  (token_index)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Local copy of the scanner state.
    mode_t                   scan_state;
    logic [3:0]              digit_count;
    logic [DEPTH_WIDTH-1:0]  nest_depth;
    logic [OFFSET_WIDTH-1:0] origin_offset;
    logic [OFFSET_WIDTH-1:0] next_offset;
    logic [31:0]             token_count;
    logic [2:0]              open_kind;

    color_token_t expected_tokens[$];
    int unsigned  mismatches = 0;
    int unsigned  burst_left = 0;
    int unsigned  items_sent = 0;
    bit           gaps_enabled = 1'b1;

    string hex_chars  = "0123456789abcdefABCDEF";
    string body_chars = "0123456789 ,.%/#rgbhsla";
    string hot_chars  = "#rgbhsla()";

    function automatic logic is_hex_char(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_A && b <= CH_LOW_F) ||
               (b >= CH_UP_A && b <= CH_UP_F);
    endfunction

    function automatic string prefix_text(input int unsigned k);
        case (k)
            0:       return "rgb(";
            1:       return "rgba(";
            2:       return "hsl(";
            default: return "hsla(";
        endcase
    endfunction

    task automatic reset_scanner();
        scan_state    = M_IDLE;
        digit_count   = '0;
        nest_depth    = '0;
        origin_offset = '0;
        next_offset   = '0;
        token_count   = '0;
        open_kind     = '0;
    endtask

    task automatic record_token(input logic [2:0] kind, input logic [31:0] start,
                                input logic [31:0] length);
        expected_tokens.push_back('{kind, start, length, token_count});
        token_count = token_count + 32'd1;
    endtask

    task automatic open_function(input logic [2:0] kind);
        scan_state = M_FUNC;
        open_kind  = kind;
        nest_depth = DEPTH_WIDTH'(1);
    endtask

    // Advance the local scanner by one text beat and queue any token it ends.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic                    rescan;
        logic                    found;
        logic [OFFSET_WIDTH-1:0] off;
        rescan = 1'b0;
        found  = 1'b0;
        off    = next_offset;
        case (scan_state)
            M_HEX:
            begin
                if (is_hex_char(b))
                begin
                    digit_count = digit_count + 4'd1;
                    if (digit_count >= HEX_MAX_DIGITS)
                    begin
                        record_token(K_HEX, origin_offset, 32'(digit_count) + 32'd1);
                        found       = 1'b1;
                        scan_state  = M_IDLE;
                        digit_count = '0;
                    end
                end
                else
                begin
                    if (digit_count >= 4'(HEX_MIN_DIGITS))
                    begin
                        record_token(K_HEX, origin_offset, 32'(digit_count) + 32'd1);
                        found = 1'b1;
                    end
                    scan_state  = M_IDLE;
                    digit_count = '0;
                    rescan      = 1'b1;
                end
            end
            M_FUNC:
            begin
                if (b == CH_LPAREN)
                begin
                    if (nest_depth != DEPTH_MAX)
                        nest_depth = nest_depth + 1'b1;
                end
                else if (b == CH_RPAREN)
                begin
                    if (nest_depth != '0)
                        nest_depth = nest_depth - 1'b1;
                    if (nest_depth == '0)
                    begin
                        record_token(open_kind, origin_offset, off - origin_offset + 1'b1);
                        found      = 1'b1;
                        scan_state = M_IDLE;
                        open_kind  = '0;
                    end
                end
            end
            M_R:  if (b == CH_G) scan_state = M_RG; else rescan = 1'b1;
            M_RG: if (b == CH_B) scan_state = M_RGB; else rescan = 1'b1;
            M_RGB:
            begin
                if (b == CH_A)
                    scan_state = M_RGBA;
                else if (b == CH_LPAREN)
                    open_function(K_RGB);
                else
                    rescan = 1'b1;
            end
            M_RGBA: if (b == CH_LPAREN) open_function(K_RGBA); else rescan = 1'b1;
            M_H:    if (b == CH_S) scan_state = M_HS; else rescan = 1'b1;
            M_HS:   if (b == CH_L) scan_state = M_HSL; else rescan = 1'b1;
            M_HSL:
            begin
                if (b == CH_A)
                    scan_state = M_HSLA;
                else if (b == CH_LPAREN)
                    open_function(K_HSL);
                else
                    rescan = 1'b1;
            end
            M_HSLA: if (b == CH_LPAREN) open_function(K_HSLA); else rescan = 1'b1;
            default: rescan = 1'b1;
        endcase

        // A byte that breaks the current match is looked at again from idle.
        if (rescan)
        begin
            scan_state = M_IDLE;
            if (b == CH_HASH)
            begin
                scan_state    = M_HEX;
                digit_count   = '0;
                origin_offset = off;
            end
            else if (b == CH_R)
            begin
                scan_state    = M_R;
                origin_offset = off;
            end
            else if (b == CH_H)
            begin
                scan_state    = M_H;
                origin_offset = off;
            end
        end

        next_offset = off + 1'b1;

        // The final beat flushes a pending hex run and clears everything.
        if (last)
        begin
            if (!found && scan_state == M_HEX && digit_count >= 4'(HEX_MIN_DIGITS))
                record_token(K_HEX, origin_offset, 32'(digit_count) + 32'd1);
            reset_scanner();
        end
    endtask

    // Drive one text beat, with a random gap before each new burst.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gaps_enabled)
            begin
                repeat (gap)
                begin
                    @(negedge clk);
                    text_valid <= 1'b0;
                end
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        text_valid  <= 1'b1;
        text_byte   <= b;
        end_of_text <= last;
        do
            @(posedge clk);
        while (!text_ready);
        predict_byte(b, last);
        items_sent = items_sent + 1;
    endtask

    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic send_bytes(ref logic [7:0] q[$], input logic last);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], last && (i == q.size() - 1));
    endtask

    // Short, long and dropped hex runs, and a run cut by a new '#'.
    task automatic test_hex_tokens();
        send_text("#0Af#12345678", 1'b0);
        send_text("9#1g#ab;", 1'b0);
    endtask

    // All four function kinds, with nesting and a hex look-alike inside.
    task automatic test_function_tokens();
        send_text("rgb(())hsla()", 1'b0);
        send_text("rgba(#fff)hsl(a)", 1'b0);
    endtask

    // Prefixes broken after r, rgb, rgba, h, hs and hsla, each breaking byte scanned again.
    task automatic test_broken_prefixes();
        send_text("rrgb)hs#abc)rgbx", 1'b0);
        send_text("hslah(rgbah(", 1'b0);
    endtask

    // End of text: flush, unclosed function, short run, full run, closed function, top bits.
    task automatic test_end_of_text();
        send_text("#abcd", 1'b1);
        send_text("hsl((", 1'b1);
        send_text("#12", 1'b1);
        send_text("#abcdef01", 1'b1);
        send_text("rgb()", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    // Deep nesting sent back to back; only the outermost close ends the token.
    task automatic test_deep_nesting();
        gaps_enabled = 1'b0;
        send_text("rgb(", 1'b0);
        repeat (NEST_LEVELS) send_byte(CH_LPAREN, 1'b0);
        repeat (NEST_LEVELS) send_byte(CH_RPAREN, 1'b0);
        send_text(")", 1'b1);
        gaps_enabled = 1'b1;
    endtask

    // Mostly well-formed tokens with random content, mixed with noise.
    task automatic test_random_text();
        logic [7:0]  frag[$];
        frag_kind_t  shape;
        string       pfx;
        int unsigned first_item;
        int unsigned depth;
        int unsigned pick;
        int unsigned keep;
        logic        unclosed;
        logic        last;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            frag.delete();
            unclosed = 1'b0;
            pick = $urandom_range(0, 9);
            shape = (pick < 3) ? FRAG_HEX : (pick < 6) ? FRAG_FUNC :
                    (pick < 8) ? FRAG_BROKEN : FRAG_NOISE;
            case (shape)
                FRAG_HEX:
                begin
                    frag.push_back(CH_HASH);
                    repeat ($urandom_range(0, 10))
                        frag.push_back(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
                    if ($urandom_range(0, 2) != 0)
                        frag.push_back(body_chars[$urandom_range(0, body_chars.len() - 1)]);
                end
                FRAG_FUNC:
                begin
                    pfx = prefix_text($urandom_range(0, 3));
                    for (int i = 0; i < pfx.len(); i++)
                        frag.push_back(pfx[i]);
                    depth = 1;
                    repeat ($urandom_range(0, 10))
                    begin
                        pick = $urandom_range(0, 5);
                        if (pick == 0)
                        begin
                            frag.push_back(CH_LPAREN);
                            depth = depth + 1;
                        end
                        else if (pick == 1 && depth > 1)
                        begin
                            frag.push_back(CH_RPAREN);
                            depth = depth - 1;
                        end
                        else
                        begin
                            frag.push_back(body_chars[$urandom_range(0, body_chars.len() - 1)]);
                        end
                    end
                    unclosed = ($urandom_range(0, 9) == 0);
                    if (!unclosed)
                        repeat (depth) frag.push_back(CH_RPAREN);
                end
                FRAG_BROKEN:
                begin
                    pfx  = prefix_text($urandom_range(0, 3));
                    keep = $urandom_range(1, pfx.len() - 1);
                    for (int i = 0; i < keep; i++)
                        frag.push_back(pfx[i]);
                    frag.push_back(hot_chars[$urandom_range(0, hot_chars.len() - 1)]);
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            frag.push_back(8'($urandom_range(1, 255)));
                        else
                            frag.push_back(hot_chars[$urandom_range(0, hot_chars.len() - 1)]);
                    end
                end
            endcase
            // An open function would swallow all later text, so end the text there.
            last = unclosed || ($urandom_range(0, 11) == 0);
            send_bytes(frag, last);
        end
        send_byte(CH_SPACE, 1'b1);
    endtask

    // Token side stalls in phases: always ready, coin toss, mostly stalled, periodic.
    initial
    begin : token_sink
        int unsigned phase_left;
        int unsigned style;
        phase_left = 0;
        style      = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                style      = $urandom_range(0, 3);
                phase_left = $urandom_range(10, 150);
            end
            phase_left = phase_left - 1;
            case (style)
                0:       token_ready <= 1'b1;
                1:       token_ready <= ($urandom_range(0, 1) == 1);
                2:       token_ready <= ($urandom_range(0, 4) == 0);
                default: token_ready <= ((phase_left % 8) < 3);
            endcase
        end
    end

    task automatic note_failure(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Compare every token beat with the oldest predicted token.
    always @(posedge clk)
    begin : token_check
        color_token_t seen;
        color_token_t want;
        if (rst_n && token_valid && token_ready)
        begin
            seen = '{token_kind, token_start, token_length, token_index};
            if (expected_tokens.size() == 0)
            begin
                note_failure($sformatf("unexpected token: kind %0d start %0d length %0d index %0d",
                                       seen.kind, seen.start, seen.length, seen.index));
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (seen.kind !== want.kind || seen.start !== want.start ||
                    seen.length !== want.length || seen.index !== want.index)
                    note_failure($sformatf(
                        "token mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        want.kind, want.start, want.length, want.index,
                        seen.kind, seen.start, seen.length, seen.index));
            end
        end
    end

    // Watchdog: too many cycles with no beat on either channel.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((text_valid && text_ready) || (token_valid && token_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("status: fail");
        $finish;
    end

    // Test sequence.
    initial
    begin
        reset_scanner();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hex_tokens();
        test_function_tokens();
        test_broken_prefixes();
        test_end_of_text();
        test_deep_nesting();
        test_random_text();

        @(negedge clk);
        text_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
